/* design/assert_macros.svh */
// Assertion macros included by the running median top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

/* design/rmh_pkg.sv */
// Shared constants and types of the running median block.
`timescale 1ns / 1ps
`default_nettype none
package rmh_pkg;
	localparam int Capacity = 256;
	localparam int Half = (Capacity + 1) / 2;
	localparam int AddrW = $clog2(Half);
	localparam int SizeW = $clog2(Half + 1);
	localparam int TotW = $clog2(Capacity + 1);
	localparam int CountW = 9;
	localparam int DataW = 32;
	typedef logic [AddrW-1:0] addr_t;
	typedef logic [SizeW-1:0] size_t;
	typedef logic signed [DataW-1:0] data_t;
endpackage
`default_nettype wire

/* design/rmh_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module rmh_ram #(
	parameter int Width = 32,
	parameter int Depth = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

/* design/running_median_two_heaps.sv */
// Top level of the running median block: sequencer over two heap memories.
`timescale 1ns / 1ps
`default_nettype none
// Running median over a stream of signed 32-bit samples.
// Input word (s_axis): tdata[31:0] = sample, tuser = first_of_stream, which
// empties both heaps before the sample goes in.
// Output word (m_axis): tdata[31:0] median, [40:32] held_count, [41] dropped.
// One result word per input word, in order.
// The lower half lives in a max-heap RAM and the upper half in a min-heap RAM,
// each 128 entries with a registered read. A sequencer performs the heap
// operations one memory access at a time: each sift-up level reads the parent
// and then compares and writes, each sift-down level reads two children and
// then compares and writes.
// A drop goes straight to reading the tops and loading the output register;
// an insert reads the tops and decides, runs the sift-up (up to 7 swapped
// levels plus the final write), a sift-down when an element moves across (up
// to 7 levels plus the final write), and then reads the tops and loads the
// output register.
// One item is processed at a time; s_axis_tready is high only while the
// sequencer is idle, so a new word is taken at the earliest in the cycle after
// the previous result is loaded.
// The output register holds its word while m_axis_tready is low, and the
// sequencer waits there before finishing the next item.
// Reset clears sizes, the sequencer and the output valid; heap contents are
// not cleared, as entries above the sizes are never read.
module running_median_two_heaps (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [31:0] sample
	input  wire logic        s_axis_tuser,  // first_of_stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata   // [31:0] median, [40:32] held_count, [41] dropped
);
`include "assert_macros.svh"
	localparam logic [3:0] StIdle   = 4'd0;
	localparam logic [3:0] StTopRd  = 4'd1;  // read both tops
	localparam logic [3:0] StDecide = 4'd2;
	localparam logic [3:0] StUpRd   = 4'd3;  // read parent in sift-up
	localparam logic [3:0] StUpCmp  = 4'd4;
	localparam logic [3:0] StDnRdL  = 4'd5;  // read left child
	localparam logic [3:0] StDnRdR  = 4'd6;  // read right child
	localparam logic [3:0] StDnCmp  = 4'd7;
	localparam logic [3:0] StMedRd  = 4'd8;  // read tops for median
	localparam logic [3:0] StMedWt  = 4'd9;
	localparam logic [3:0] StOut    = 4'd10;

	logic [3:0] state_q;
	rmh_pkg::size_t lsize_q, usize_q;
	rmh_pkg::data_t x_q, val_q, ltop_q, utop_q, lchild_q;
	logic dropped_q;
	// current heap operation: heap select (1 = lower/max) and position
	logic hsel_q;
	rmh_pkg::addr_t pos_q;
	rmh_pkg::size_t hn_q;      // size of heap in sift-down
	logic dn_pend_q;           // sift-down on the other heap after push
	logic dn_sel_q;
	rmh_pkg::data_t dn_val_q;

	logic l_we, u_we;
	rmh_pkg::addr_t l_addr, u_addr;
	rmh_pkg::data_t l_wd, u_wd, l_rd, u_rd;

	rmh_ram #(.Width(rmh_pkg::DataW), .Depth(rmh_pkg::Half)) u_lower (
		.clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wd), .rdata(l_rd));
	rmh_ram #(.Width(rmh_pkg::DataW), .Depth(rmh_pkg::Half)) u_upper (
		.clk(clk), .we(u_we), .addr(u_addr), .wdata(u_wd), .rdata(u_rd));

	logic out_free;
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = (state_q == StIdle);

	// position arithmetic
	rmh_pkg::addr_t parent, lchild, rchild;
	logic [rmh_pkg::AddrW:0] l_ext;
	logic [rmh_pkg::AddrW+1:0] r_ext;
	assign parent = rmh_pkg::AddrW'((pos_q - rmh_pkg::addr_t'(1)) >> 1);
	assign l_ext = {pos_q, 1'b1};
	assign r_ext = {1'b0, l_ext} + (rmh_pkg::AddrW+2)'(1);
	assign lchild = l_ext[rmh_pkg::AddrW-1:0];
	assign rchild = r_ext[rmh_pkg::AddrW-1:0];
	logic l_in, r_in;
	assign l_in = {1'b0, l_ext} < (rmh_pkg::AddrW+2)'(hn_q);
	assign r_in = r_ext < (rmh_pkg::AddrW+2)'(hn_q);

	rmh_pkg::data_t rd_sel;
	assign rd_sel = hsel_q ? l_rd : u_rd;
	// true when a ranks above b in the selected heap
	function automatic logic above(input logic is_max, input rmh_pkg::data_t a,
		input rmh_pkg::data_t b);
		above = is_max ? (a > b) : (a < b);
	endfunction

	logic up_swap;
	assign up_swap = above(hsel_q, val_q, rd_sel);
	// best of value and children during sift-down
	logic dn_l, dn_r;
	rmh_pkg::data_t best_lv;
	assign dn_l = l_in && above(hsel_q, lchild_q, val_q);
	assign best_lv = dn_l ? lchild_q : val_q;
	assign dn_r = r_in && above(hsel_q, rd_sel, best_lv);

	logic signed [32:0] msum;
	logic signed [32:0] mhalf;
	assign msum = 33'(ltop_q) + 33'(utop_q);
	assign mhalf = (msum + 33'(msum[32])) >>> 1;

	always_comb begin
		l_we = 1'b0; u_we = 1'b0;
		l_wd = val_q; u_wd = val_q;
		l_addr = pos_q; u_addr = pos_q;
		unique case (state_q)
			StTopRd, StMedRd: begin
				l_addr = '0; u_addr = '0;
			end
			StUpRd: begin
				l_addr = parent; u_addr = parent;
			end
			StUpCmp: begin
				// write the parent value down, or the value at its final place;
				// at the root there is no parent, so the value always lands there
				l_we = hsel_q; u_we = !hsel_q;
				if (up_swap && pos_q != '0) begin
					l_wd = rd_sel; u_wd = rd_sel;
				end
			end
			StDnRdL: begin
				l_addr = lchild; u_addr = lchild;
			end
			StDnRdR: begin
				l_addr = rchild; u_addr = rchild;
			end
			StDnCmp: begin
				l_we = hsel_q; u_we = !hsel_q;
				if (dn_r) begin
					l_wd = rd_sel; u_wd = rd_sel;
				end else if (dn_l) begin
					l_wd = lchild_q; u_wd = lchild_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			lsize_q <= '0;
			usize_q <= '0;
			m_axis_tvalid <= 1'b0;
			dn_pend_q <= 1'b0;
		end else begin
			if (state_q == StOut && out_free) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				StIdle: if (s_axis_tvalid) begin
					x_q <= s_axis_tdata;
					if (s_axis_tuser) begin
						lsize_q <= '0; usize_q <= '0;
					end
					if (!s_axis_tuser && (rmh_pkg::TotW'(lsize_q) + rmh_pkg::TotW'(usize_q)
						>= rmh_pkg::TotW'(rmh_pkg::Capacity))) begin
						dropped_q <= 1'b1;
						state_q <= StMedRd;
					end else begin
						dropped_q <= 1'b0;
						state_q <= StTopRd;
					end
				end
				StTopRd: state_q <= StDecide;
				StDecide: begin
					// push: place val at the end of heap hsel, then sift up
					state_q <= StUpRd;
					dn_pend_q <= 1'b0;
					if (lsize_q != '0 && x_q < l_rd) begin
						if (lsize_q > usize_q) begin
							hsel_q <= 1'b0; val_q <= l_rd; pos_q <= rmh_pkg::AddrW'(usize_q);
							usize_q <= usize_q + rmh_pkg::size_t'(1);
							dn_pend_q <= 1'b1; dn_sel_q <= 1'b1; dn_val_q <= x_q;
						end else begin
							hsel_q <= 1'b1; val_q <= x_q; pos_q <= rmh_pkg::AddrW'(lsize_q);
							lsize_q <= lsize_q + rmh_pkg::size_t'(1);
						end
					end else if (usize_q > lsize_q) begin
						hsel_q <= 1'b1; pos_q <= rmh_pkg::AddrW'(lsize_q);
						lsize_q <= lsize_q + rmh_pkg::size_t'(1);
						if (x_q <= u_rd) begin
							val_q <= x_q;
						end else begin
							val_q <= u_rd;
							dn_pend_q <= 1'b1; dn_sel_q <= 1'b0; dn_val_q <= x_q;
						end
					end else begin
						hsel_q <= 1'b0; val_q <= x_q; pos_q <= rmh_pkg::AddrW'(usize_q);
						usize_q <= usize_q + rmh_pkg::size_t'(1);
					end
				end
				StUpRd: begin
					// at the root the value is written in place by StUpCmp
					state_q <= StUpCmp;
				end
				StUpCmp: begin
					if (pos_q != '0 && up_swap) begin
						pos_q <= parent;
						state_q <= StUpRd;
					end else if (dn_pend_q) begin
						dn_pend_q <= 1'b0;
						hsel_q <= dn_sel_q;
						val_q <= dn_val_q;
						pos_q <= '0;
						hn_q <= dn_sel_q ? lsize_q : usize_q;
						state_q <= StDnRdL;
					end else begin
						state_q <= StMedRd;
					end
				end
				StDnRdL: state_q <= StDnRdR;
				StDnRdR: begin
					lchild_q <= rd_sel;
					state_q <= StDnCmp;
				end
				StDnCmp: begin
					if (dn_r) begin
						pos_q <= rchild;
						state_q <= StDnRdL;
					end else if (dn_l) begin
						pos_q <= lchild;
						state_q <= StDnRdL;
					end else begin
						state_q <= StMedRd;
					end
				end
				StMedRd: state_q <= StMedWt;
				StMedWt: begin
					ltop_q <= l_rd; utop_q <= u_rd;
					state_q <= StOut;
				end
				StOut: if (out_free) begin
					m_axis_tdata[40:32] <= rmh_pkg::CountW'(rmh_pkg::TotW'(lsize_q)
						+ rmh_pkg::TotW'(usize_q));
					m_axis_tdata[41] <= dropped_q;
					m_axis_tdata[47:42] <= '0;
					if (lsize_q == '0 && usize_q == '0) begin
						m_axis_tdata[31:0] <= '0;
					end else if (lsize_q == usize_q) begin
						m_axis_tdata[31:0] <= mhalf[31:0];
					end else if (lsize_q > usize_q) begin
						m_axis_tdata[31:0] <= ltop_q;
					end else begin
						m_axis_tdata[31:0] <= utop_q;
					end
					state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// Sift-up: a swap write places the parent at pos; the value itself is written
	// at its final position by the non-swap StUpCmp write (val at pos).

	logic bal_ok;
	assign bal_ok = (lsize_q <= usize_q + rmh_pkg::size_t'(1))
		&& (usize_q <= lsize_q + rmh_pkg::size_t'(1));

	`ASSERT_NEVER(a_lsize_cap, clk, arst_n, lsize_q > rmh_pkg::SizeW'(rmh_pkg::Half))
	`ASSERT_NEVER(a_usize_cap, clk, arst_n, usize_q > rmh_pkg::SizeW'(rmh_pkg::Half))
	`ASSERT_CLK(a_bal, clk, arst_n, (state_q == StOut) |-> bal_ok)
	`ASSERT_CLK(a_out, clk, arst_n, (state_q == StOut && out_free) |=> m_axis_tvalid)
endmodule
`default_nettype wire

/* bench/tb_running_median_two_heaps.sv */
// Self-checking bench for the two-heap running median block.
`timescale 1ns / 1ps
`default_nettype none

// Keeps its own model of both heaps and a queue of predicted median words.
class median_scoreboard;
	logic signed [31:0] lo_heap [128];
	logic signed [31:0] hi_heap [128];
	int lo_n;
	int hi_n;
	logic [47:0] pending [$];
	int errors;

	function new();
		lo_n = 0;
		hi_n = 0;
		errors = 0;
	endfunction

	// Pushes onto a heap; is_max selects max-heap ordering.
	function void push_val(bit is_max, logic signed [31:0] v);
		int i;
		int p;
		logic signed [31:0] t;
		if (is_max) begin
			i = lo_n;
			lo_heap[i] = v;
			lo_n++;
			while (i > 0) begin
				p = (i - 1) / 2;
				if (!(lo_heap[i] > lo_heap[p]))
					break;
				t = lo_heap[i]; lo_heap[i] = lo_heap[p]; lo_heap[p] = t;
				i = p;
			end
		end else begin
			i = hi_n;
			hi_heap[i] = v;
			hi_n++;
			while (i > 0) begin
				p = (i - 1) / 2;
				if (!(hi_heap[i] < hi_heap[p]))
					break;
				t = hi_heap[i]; hi_heap[i] = hi_heap[p]; hi_heap[p] = t;
				i = p;
			end
		end
	endfunction

	// Replaces the top and sifts it down.
	function void replace_top(bit is_max, logic signed [31:0] v);
		int i;
		int l;
		int r;
		int best;
		int n;
		logic signed [31:0] t;
		i = 0;
		n = is_max ? lo_n : hi_n;
		if (is_max) lo_heap[0] = v; else hi_heap[0] = v;
		forever begin
			l = 2 * i + 1;
			r = l + 1;
			best = i;
			if (is_max) begin
				if (l < n && lo_heap[l] > lo_heap[best]) best = l;
				if (r < n && lo_heap[r] > lo_heap[best]) best = r;
				if (best == i) break;
				t = lo_heap[i]; lo_heap[i] = lo_heap[best]; lo_heap[best] = t;
			end else begin
				if (l < n && hi_heap[l] < hi_heap[best]) best = l;
				if (r < n && hi_heap[r] < hi_heap[best]) best = r;
				if (best == i) break;
				t = hi_heap[i]; hi_heap[i] = hi_heap[best]; hi_heap[best] = t;
			end
			i = best;
		end
	endfunction

	function void note_sample(bit first, logic signed [31:0] x);
		logic dropped;
		logic signed [32:0] sum;
		logic signed [31:0] med;
		logic [8:0] cnt;
		if (first) begin
			lo_n = 0;
			hi_n = 0;
		end
		dropped = (lo_n + hi_n >= 256);
		if (!dropped) begin
			if (lo_n > 0 && x < lo_heap[0]) begin
				if (lo_n > hi_n) begin
					push_val(0, lo_heap[0]);
					replace_top(1, x);
				end else
					push_val(1, x);
			end else if (hi_n > lo_n) begin
				if (x <= hi_heap[0])
					push_val(1, x);
				else begin
					push_val(1, hi_heap[0]);
					replace_top(0, x);
				end
			end else
				push_val(0, x);
		end
		if (lo_n == 0 && hi_n == 0)
			med = 0;
		else if (lo_n == hi_n) begin
			sum = 33'(lo_heap[0]) + 33'(hi_heap[0]);
			// Halve with truncation toward zero.
			sum = (sum < 0) ? -((-sum) >>> 1) : (sum >>> 1);
			med = sum[31:0];
		end else
			med = (lo_n > hi_n) ? lo_heap[0] : hi_heap[0];
		cnt = 9'(lo_n + hi_n);
		pending.push_back({6'b0, dropped, cnt, med});
	endfunction

	function void check_word(logic [47:0] got);
		logic [47:0] want;
		if (pending.size() == 0) begin
			$display("%0t: unexpected word %h", $time, got);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got[31:0] !== want[31:0]) begin
			$display("%0t: median expected %0d actual %0d", $time,
				$signed(want[31:0]), $signed(got[31:0]));
			errors++;
		end
		if (got[40:32] !== want[40:32]) begin
			$display("%0t: held_count expected %0d actual %0d", $time,
				want[40:32], got[40:32]);
			errors++;
		end
		if (got[41] !== want[41]) begin
			$display("%0t: dropped expected %0b actual %0b", $time, want[41], got[41]);
			errors++;
		end
	endfunction
endclass

module tb_running_median_two_heaps;
	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;  // [31:0] sample
	logic        s_axis_tuser;  // first_of_stream
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;  // [31:0] median, [40:32] held_count, [41] dropped

	median_scoreboard board;
	int  cycles;
	bit  sink_hold;     // Long hold-off of the receiver, set by the stimulus.
	bit  sink_timed;    // When clear, the receiver draws no idle gaps; only the long hold-off can still stall it.
	bit  src_timed;

	running_median_two_heaps dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b0; #1;
		clk = 1'b1; #1;
	end

	// Watchdog: a correct run is far shorter than this.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 800000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Check each word as it is accepted at the rising edge.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_word(m_axis_tdata);
	end

	// Receiver: draws an idle count per word, and honors the long hold-off.
	initial begin : sink
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = sink_timed ? $urandom_range(0, 18) : 0;
			if (sink_hold) begin
				m_axis_tready <= 1'b0;
				repeat (300) @(negedge clk);
				sink_hold = 1'b0;
			end else if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	// Offers one word after a random gap and waits for its handshake; the
	// valid is dropped only while a gap runs, so words can go back to back.
	task automatic send_word(bit first, logic [31:0] x);
		int gap;
		gap = src_timed ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= x;
		s_axis_tuser  <= first;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note_sample(first, x);
		@(negedge clk);
	endtask

	// Samples clustered on a few values so ties and equal tops are common.
	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 40)) - 20);
			2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			3: return {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'($urandom())};
			default: return 32'($urandom_range(0, 7)) << $urandom_range(0, 31);
		endcase
	endfunction

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin : stim
		int len;
		int sent;
		board = new();
		cycles = 0;
		sink_hold = 0;
		sink_timed = 1;
		src_timed = 1;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extremes, an overflow-prone even-count sum, and negative
		// averages that must truncate toward zero.
		send_word(1, 32'h7fff_ffff);
		send_word(0, 32'h7fff_ffff);
		send_word(0, 32'h8000_0000);
		send_word(0, 32'h8000_0000);
		send_word(1, 32'hffff_fffd);
		send_word(0, 32'h0000_0000);
		send_word(0, 32'hffff_ffff);
		send_word(0, 32'd5);
		send_word(0, 32'hffff_fffb);
		send_word(1, 32'd10);
		send_word(0, 32'd10);
		send_word(0, 32'd3);
		send_word(0, 32'd20);
		send_word(0, 32'd1);
		send_word(0, 32'd30);

		// Fill to capacity, then a few that must be dropped, with the
		// receiver holding off so the block backs up and stalls its input.
		sink_hold = 1'b1;
		src_timed = 0;
		send_word(1, pick_sample());
		repeat (259) send_word(0, pick_sample());
		src_timed = 1;
		// Sender pauses until every expected word has come.
		drain();

		// Random streams: mostly short, a few long enough to fill up.
		sent = 0;
		while (sent < 1150) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 270)
				: $urandom_range(1, 30);
			sink_timed = ($urandom_range(0, 3) != 0);
			src_timed = ($urandom_range(0, 3) != 0);
			send_word(1, pick_sample());
			repeat (len - 1) send_word($urandom_range(0, 60) == 0, pick_sample());
			sent += len;
		end
		sink_timed = 1;
		drain();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
